// ===== hw/rtl/lscu_pkg.sv =====
package lscu_pkg;

  // Command codes carried in the operation field.
  typedef enum logic [3:0] {
    OP_TOGGLE      = 4'd0,
    OP_ON          = 4'd1,
    OP_OFF         = 4'd2,
    OP_HUE_UP      = 4'd3,
    OP_HUE_DOWN    = 4'd4,
    OP_SAT_UP      = 4'd5,
    OP_SAT_DOWN    = 4'd6,
    OP_BRIGHT_UP   = 4'd7,
    OP_BRIGHT_DOWN = 4'd8,
    OP_SPEED_UP    = 4'd9,
    OP_SPEED_DOWN  = 4'd10,
    OP_EFFECT_NEXT = 4'd11,
    OP_EFFECT_PREV = 4'd12
  } lscu_op_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_HUE_STEP    = 3'd0,
    REG_SAT_STEP    = 3'd1,
    REG_BRIGHT_STEP = 3'd2,
    REG_SPEED_STEP  = 3'd3,
    REG_BRIGHT_CEIL = 3'd4
  } lscu_reg_e;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // Reset values of the configuration registers.
  localparam logic [7:0] HueStepReset    = 8'd8;
  localparam logic [7:0] SatStepReset    = 8'd16;
  localparam logic [7:0] BrightStepReset = 8'd16;
  localparam logic [7:0] SpeedStepReset  = 8'd16;
  localparam logic [7:0] BrightCeilReset = 8'd255;

  // Reset values of the lighting settings.
  localparam logic [7:0] HueReset    = 8'd0;
  localparam logic [7:0] SatReset    = 8'd255;
  localparam logic [7:0] BrightReset = 8'd255;
  localparam logic [7:0] SpeedReset  = 8'd127;
  localparam logic [7:0] EffectReset = 8'd1;

  typedef struct packed {
    logic [3:0] operation;
    logic       pressed;
    logic       shift_held;
  } lscu_in_t;

  typedef struct packed {
    logic       lights_on;
    logic [7:0] hue_now;
    logic [7:0] saturation_now;
    logic [7:0] brightness_now;
    logic [7:0] speed_now;
    logic [7:0] effect_now;
    logic       restart_effect;
    logic       save_request;
  } lscu_out_t;

  typedef struct packed {
    logic [7:0] hue_step;
    logic [7:0] saturation_step;
    logic [7:0] brightness_step;
    logic [7:0] speed_step;
    logic [7:0] brightness_ceiling;
  } lscu_cfg_t;

  // Saturating move of an 8-bit value by a step, up or down.
  function automatic logic [7:0] sat_move(logic [7:0] v, logic [7:0] step, logic up);
    logic [8:0] sum;
    begin
      sum = {1'b0, v} + {1'b0, step};
      if (up) begin
        sat_move = sum[8] ? 8'hFF : sum[7:0];
      end else begin
        sat_move = (v > step) ? (v - step) : 8'd0;
      end
    end
  endfunction

endpackage

// ===== hw/rtl/led_setting_command_unit.sv =====
// Items pass through an input and a result register; one item per cycle
// unless the output stalls. The settings registers are updated by saturating
// or wrapping steps and a brightness clamp between the input and result
// registers. Reset (asynchronous, active low) empties both stages and
// restores the default settings and step registers.
module led_setting_command_unit
  import lscu_pkg::*;
#(
  parameter int unsigned EffectCount = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lscu_in_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lscu_out_t            out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  lscu_cfg_t cfg;
  lscu_in_t  item_q;
  lscu_out_t res;
  lscu_out_t res_q;
  logic      item_valid_q;
  logic      res_valid_q;
  logic      advance;

  lscu_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The stored item moves to the result register when that has room.
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  lscu_update #(
    .EffectCount (EffectCount)
  ) u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule

// ===== hw/rtl/lscu_cfg_regs.sv =====
module lscu_cfg_regs
  import lscu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output lscu_cfg_t            cfg_o
);

  lscu_cfg_t cfg_q, cfg_d;
  lscu_reg_e reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = lscu_reg_e'(paddr[AddrWidth-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register write decode; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_HUE_STEP:    cfg_d.hue_step           = pwdata[7:0];
        REG_SAT_STEP:    cfg_d.saturation_step    = pwdata[7:0];
        REG_BRIGHT_STEP: cfg_d.brightness_step    = pwdata[7:0];
        REG_SPEED_STEP:  cfg_d.speed_step         = pwdata[7:0];
        REG_BRIGHT_CEIL: cfg_d.brightness_ceiling = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_step           <= HueStepReset;
      cfg_q.saturation_step    <= SatStepReset;
      cfg_q.brightness_step    <= BrightStepReset;
      cfg_q.speed_step         <= SpeedStepReset;
      cfg_q.brightness_ceiling <= BrightCeilReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (reg_idx)
      REG_HUE_STEP:    prdata = {24'd0, cfg_q.hue_step};
      REG_SAT_STEP:    prdata = {24'd0, cfg_q.saturation_step};
      REG_BRIGHT_STEP: prdata = {24'd0, cfg_q.brightness_step};
      REG_SPEED_STEP:  prdata = {24'd0, cfg_q.speed_step};
      REG_BRIGHT_CEIL: prdata = {24'd0, cfg_q.brightness_ceiling};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/lscu_update.sv =====
module lscu_update
  import lscu_pkg::*;
#(
  parameter int unsigned EffectCount = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      commit_i,
  input  lscu_in_t  item_i,
  input  lscu_cfg_t cfg_i,
  output lscu_out_t res_o
);

  localparam logic [8:0] EffectLimit = 9'(EffectCount);
  localparam logic [7:0] EffectLast  = 8'(EffectCount - 1);

  logic       en_q, en_d;
  logic [7:0] hue_q, hue_d;
  logic [7:0] sat_q, sat_d;
  logic [7:0] bri_q, bri_d;
  logic [7:0] spd_q, spd_d;
  logic [7:0] eff_q, eff_d;
  logic       restart;
  logic       fwd;
  logic [7:0] bri_moved;
  logic [8:0] eff_inc;
  logic [7:0] eff_next;
  logic [7:0] eff_prev;
  lscu_op_e   op;

  assign op  = lscu_op_e'(item_i.operation);
  assign fwd = !item_i.shift_held;

  // Candidate values shared by the command decode below.
  assign bri_moved = sat_move(bri_q, cfg_i.brightness_step,
                              (op == OP_BRIGHT_UP) == fwd);
  assign eff_inc   = {1'b0, eff_q} + 9'd1;
  assign eff_next  = (eff_inc >= EffectLimit) ? 8'd1 : eff_inc[7:0];
  assign eff_prev  = (eff_q <= 8'd1) ? EffectLast : (eff_q - 8'd1);

  // Command decode; releases leave everything unchanged.
  always_comb begin
    en_d    = en_q;
    hue_d   = hue_q;
    sat_d   = sat_q;
    bri_d   = bri_q;
    spd_d   = spd_q;
    eff_d   = eff_q;
    restart = 1'b0;
    if (item_i.pressed) begin
      case (op)
        OP_TOGGLE: begin
          en_d    = !en_q;
          restart = 1'b1;
        end
        OP_ON: begin
          en_d    = 1'b1;
          restart = !en_q;
        end
        OP_OFF: begin
          en_d    = 1'b0;
          restart = en_q;
        end
        OP_HUE_UP, OP_HUE_DOWN: begin
          if (en_q) begin
            hue_d = ((op == OP_HUE_UP) == fwd) ? (hue_q + cfg_i.hue_step)
                                               : (hue_q - cfg_i.hue_step);
          end
        end
        OP_SAT_UP, OP_SAT_DOWN: begin
          if (en_q) begin
            sat_d = sat_move(sat_q, cfg_i.saturation_step, (op == OP_SAT_UP) == fwd);
          end
        end
        OP_BRIGHT_UP, OP_BRIGHT_DOWN: begin
          if (en_q) begin
            bri_d = (bri_moved > cfg_i.brightness_ceiling) ? cfg_i.brightness_ceiling
                                                           : bri_moved;
          end
        end
        OP_SPEED_UP, OP_SPEED_DOWN: begin
          if (en_q) begin
            spd_d = sat_move(spd_q, cfg_i.speed_step, (op == OP_SPEED_UP) == fwd);
          end
        end
        OP_EFFECT_NEXT, OP_EFFECT_PREV: begin
          if (en_q) begin
            eff_d   = ((op == OP_EFFECT_NEXT) == fwd) ? eff_next : eff_prev;
            restart = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Settings registers move on only when the item is passed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b1;
      hue_q <= HueReset;
      sat_q <= SatReset;
      bri_q <= BrightReset;
      spd_q <= SpeedReset;
      eff_q <= EffectReset;
    end else if (commit_i) begin
      en_q  <= en_d;
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= bri_d;
      spd_q <= spd_d;
      eff_q <= eff_d;
    end
  end

  assign res_o.lights_on      = en_d;
  assign res_o.hue_now        = hue_d;
  assign res_o.saturation_now = sat_d;
  assign res_o.brightness_now = bri_d;
  assign res_o.speed_now      = spd_d;
  assign res_o.effect_now     = eff_d;
  assign res_o.restart_effect = restart;
  assign res_o.save_request   = item_i.pressed;

endmodule
